[rtl/vsr_pkg.sv]
package vsr_pkg;

  // Width of the velocity ports and registers as seen outside the block
  localparam int unsigned PORT_VEL_BITS = 32;
  // Signed width that holds a velocity difference and the full step limit
  localparam int unsigned CMP_BITS      = 33;
  localparam int unsigned RATE_BITS     = 31;
  localparam int unsigned SHIFT_BITS    = 16;

  // Item codes
  typedef enum logic {
    FUNC_SET  = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_VELOCITY   = 2'd0,
    REG_MAX_VELOCITY   = 2'd1,
    REG_MAX_STEP       = 2'd2,
    REG_SHIFT_DELAY    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PORT_VEL_BITS-1:0] min_velocity;
    logic [PORT_VEL_BITS-1:0] max_velocity;
    logic [RATE_BITS-1:0]     max_step;
    logic [SHIFT_BITS-1:0]    shift_delay;
  } cfg_t;

  typedef struct packed {
    logic                     status;
    logic                     drive_valid;
    logic [PORT_VEL_BITS-1:0] current_velocity;
    logic [PORT_VEL_BITS-1:0] target_velocity;
    logic                     ramping;
  } res_t;

endpackage

[rtl/vsr_cfg.sv]
module vsr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  output vsr_pkg::cfg_t                  cfg
);

  // Take a register write on every request
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_velocity   <= '0;
      cfg.max_velocity   <= '0;
      cfg.max_step       <= vsr_pkg::RATE_BITS'(1);
      cfg.shift_delay    <= vsr_pkg::SHIFT_BITS'(1);
    end else if (cfg_valid) begin
      unique case (vsr_pkg::cfg_idx_t'(cfg_index))
        vsr_pkg::REG_MIN_VELOCITY:   cfg.min_velocity   <= cfg_data;
        vsr_pkg::REG_MAX_VELOCITY:   cfg.max_velocity   <= cfg_data;
        vsr_pkg::REG_MAX_STEP:       cfg.max_step       <= cfg_data[vsr_pkg::RATE_BITS-1:0];
        vsr_pkg::REG_SHIFT_DELAY:    cfg.shift_delay    <= cfg_data[vsr_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/vsr_step.sv]
module vsr_step #(
  parameter int unsigned VELOCITY_BITS = 32,
  parameter int unsigned DELAY_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic                           func,
  input  logic [31:0]                    target_value,
  input  vsr_pkg::cfg_t                  cfg,
  output vsr_pkg::res_t                  res
);

  localparam int unsigned CW = vsr_pkg::CMP_BITS;

  logic signed [VELOCITY_BITS-1:0] velocity_now, velocity_now_next;
  logic signed [VELOCITY_BITS-1:0] velocity_goal, velocity_goal_next;
  logic                            ramp_active, ramp_active_next;
  logic [DELAY_BITS-1:0]           delay_left, delay_left_next;

  logic signed [VELOCITY_BITS-1:0] tv, vmin, vmax, stepped;
  logic signed [VELOCITY_BITS:0]   delta;
  logic signed [CW-1:0]            delta_w, rate_w, rate_neg, step_w, sum_w;
  logic [31:0]                     shift_ext;
  logic [DELAY_BITS-1:0]           reload, delay_dec;
  logic                            out_of_range, status, drive;

  // Velocities live in the low bits of the 32-bit fields
  assign tv   = target_value[VELOCITY_BITS-1:0];
  assign vmin = cfg.min_velocity[VELOCITY_BITS-1:0];
  assign vmax = cfg.max_velocity[VELOCITY_BITS-1:0];
  assign out_of_range = (tv < vmin) || (tv > vmax);

  // Delay reload, zero counts as one tick
  assign shift_ext = 32'(cfg.shift_delay);
  assign reload    = (shift_ext[DELAY_BITS-1:0] == '0) ? DELAY_BITS'(1)
                                                       : shift_ext[DELAY_BITS-1:0];
  assign delay_dec = delay_left - DELAY_BITS'(1);

  // Clamp the distance to the target by the step limit
  assign delta    = (VELOCITY_BITS+1)'(velocity_goal) - (VELOCITY_BITS+1)'(velocity_now);
  assign delta_w  = CW'(delta);
  assign rate_w   = signed'(CW'(cfg.max_step));
  assign rate_neg = -rate_w;

  always_comb begin
    priority if (delta_w > rate_w) begin
      step_w = rate_w;
    end else if (delta_w < rate_neg) begin
      step_w = rate_neg;
    end else begin
      step_w = delta_w;
    end
  end

  assign sum_w   = CW'(velocity_now) + step_w;
  assign stepped = sum_w[VELOCITY_BITS-1:0];

  // Next state for one request
  always_comb begin
    velocity_now_next  = velocity_now;
    velocity_goal_next = velocity_goal;
    ramp_active_next   = ramp_active;
    delay_left_next    = delay_left;
    status             = 1'b0;
    drive              = 1'b0;
    if (fire) begin
      if (vsr_pkg::func_t'(func) == vsr_pkg::FUNC_SET) begin
        if (out_of_range) begin
          status = 1'b1;
        end else begin
          velocity_goal_next = tv;
          if ((tv != velocity_now) && !ramp_active) begin
            ramp_active_next = 1'b1;
            delay_left_next  = reload;
          end
        end
      end else if (ramp_active) begin
        delay_left_next = delay_dec;
        if (delay_dec == '0) begin
          velocity_now_next = stepped;
          drive             = 1'b1;
          if (stepped == velocity_goal) begin
            ramp_active_next = 1'b0;
          end else begin
            delay_left_next = reload;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_now  <= '0;
      velocity_goal <= '0;
      ramp_active   <= 1'b0;
      delay_left    <= '0;
    end else begin
      velocity_now  <= velocity_now_next;
      velocity_goal <= velocity_goal_next;
      ramp_active   <= ramp_active_next;
      delay_left    <= delay_left_next;
    end
  end

  // Result for the request, sign-extended to the port width
  assign res.status           = status;
  assign res.drive_valid      = drive;
  assign res.current_velocity = vsr_pkg::PORT_VEL_BITS'(velocity_now_next);
  assign res.target_velocity  = vsr_pkg::PORT_VEL_BITS'(velocity_goal_next);
  assign res.ramping          = ramp_active_next;

`ifndef SYNTHESIS
  a_drive_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    fire && res.drive_valid |-> func && ramp_active)
    else $error("drive update without a running ramp tick");

  a_reject_holds_state: assert property (@(posedge clk) disable iff (rst)
    fire && res.status |=> $stable(velocity_now) && $stable(velocity_goal)
                           && $stable(ramp_active) && $stable(delay_left))
    else $error("rejected target changed the ramp state");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    fire && func && !ramp_active |=> $stable(velocity_now) && !ramp_active)
    else $error("tick while idle changed the velocity");

  a_stop_at_goal: assert property (@(posedge clk) disable iff (rst)
    $fell(ramp_active) |-> velocity_now == velocity_goal)
    else $error("ramp stopped away from the target");
`endif

endmodule

[rtl/velocity_slew_ramp.sv]
// A request waits in the input register; its result is loaded into the output register
// when the output register is empty or being drained, together with the ramp state update.
// Throughput: one request per cycle while the output is not stalled.
// Reset (rst, synchronous): ramp idle, velocities and delay zero, limits zero,
// rate 1 and delay 1; both pipeline registers empty.
module velocity_slew_ramp #(
  parameter int unsigned VELOCITY_BITS = 32,
  parameter int unsigned DELAY_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] target_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        drive_valid,
  output logic [31:0] current_velocity,
  output logic [31:0] target_velocity,
  output logic        ramping,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vsr_pkg::cfg_t cfg;
  vsr_pkg::res_t res, res_q;

  logic        s1_valid;
  logic        s1_func;
  logic [31:0] s1_target;
  logic        fire;

  assign cfg_ready = 1'b1;

  vsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held request when the result register is free or draining
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func   <= func;
      s1_target <= target_value;
    end
  end

  vsr_step #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .DELAY_BITS    (DELAY_BITS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .func         (s1_func),
    .target_value (s1_target),
    .cfg          (cfg),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign status           = res_q.status;
  assign drive_valid      = res_q.drive_valid;
  assign current_velocity = res_q.current_velocity;
  assign target_velocity  = res_q.target_velocity;
  assign ramping          = res_q.ramping;

endmodule

[bench/velocity_slew_ramp_checker.sv]
`timescale 1ns / 1ps

module velocity_slew_ramp_checker
  import vsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [31:0] target_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        status,
  input  logic        drive_valid,
  input  logic [31:0] current_velocity,
  input  logic [31:0] target_velocity,
  input  logic        ramping,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output logic [31:0] model_velocity
);

  // Predicted registers and ramp state
  logic signed [31:0]   vel_floor;
  logic signed [31:0]   vel_ceiling;
  logic [RATE_BITS-1:0] step_limit;
  logic [SHIFT_BITS-1:0] step_delay;
  logic signed [31:0]   vel_now;
  logic signed [31:0]   vel_goal;
  logic                 ramp_on;
  logic [SHIFT_BITS-1:0] delay_count;

  // Results still owed by the block, oldest first
  res_t ramp_results[$];

  assign model_velocity = vel_now;

  function automatic logic [SHIFT_BITS-1:0] delay_reload();
    return (step_delay == '0) ? SHIFT_BITS'(1) : step_delay;
  endfunction

  // Advance the ramp by one request and return the result it produces
  function automatic res_t ramp_step(func_t kind, logic [31:0] value);
    res_t               r;
    logic signed [32:0] diff;
    logic signed [32:0] lim;
    r = '0;
    if (kind == FUNC_SET) begin
      if ($signed(value) < vel_floor || $signed(value) > vel_ceiling) begin
        r.status = 1'b1;
      end else begin
        vel_goal = value;
        if (vel_now != vel_goal && !ramp_on) begin
          ramp_on     = 1'b1;
          delay_count = delay_reload();
        end
      end
    end else if (ramp_on) begin
      delay_count = delay_count - SHIFT_BITS'(1);
      if (delay_count == '0) begin
        // Clamp the step to the rate limit in either direction
        diff = 33'(vel_goal) - 33'(vel_now);
        lim  = $signed({2'b00, step_limit});
        if (diff > lim) diff = lim;
        if (diff < -lim) diff = -lim;
        vel_now = vel_now + diff[31:0];
        r.drive_valid = 1'b1;
        if (vel_now == vel_goal) ramp_on = 1'b0;
        else delay_count = delay_reload();
      end
    end
    r.current_velocity = vel_now;
    r.target_velocity  = vel_goal;
    r.ramping          = ramp_on;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    res_t want;
    if (rst) begin
      vel_floor   = '0;
      vel_ceiling = '0;
      step_limit  = RATE_BITS'(1);
      step_delay  = SHIFT_BITS'(1);
      vel_now     = '0;
      vel_goal    = '0;
      ramp_on     = 1'b0;
      delay_count = '0;
      ramp_results.delete();
      fail_count  = 0;
    end else begin
      // Compare a delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (ramp_results.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, actual 0x%08h",
                   $time, current_velocity);
          fail_count++;
        end else begin
          want = ramp_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("drive_valid", 32'(want.drive_valid), 32'(drive_valid));
          check_field("current_velocity", want.current_velocity, current_velocity);
          check_field("target_velocity", want.target_velocity, target_velocity);
          check_field("ramping", 32'(want.ramping), 32'(ramping));
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_MIN_VELOCITY:   vel_floor   = cfg_data;
          REG_MAX_VELOCITY:   vel_ceiling = cfg_data;
          REG_MAX_STEP:       step_limit  = cfg_data[RATE_BITS-1:0];
          REG_SHIFT_DELAY:    step_delay  = cfg_data[SHIFT_BITS-1:0];
          default: ;
        endcase
      end
      // Predict the result of each accepted request
      if (in_valid && in_ready) begin
        ramp_results.push_back(ramp_step(func_t'(func), target_value));
      end
    end
    outstanding = ramp_results.size();
  end

endmodule

[bench/velocity_slew_ramp_tb.sv]
`timescale 1ns / 1ps

module velocity_slew_ramp_tb;
  import vsr_pkg::*;

  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [31:0] VEL_MIN = 32'h8000_0000;
  localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        func         = 1'b0;
  logic [31:0] target_value = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        status;
  logic        drive_valid;
  logic [31:0] current_velocity;
  logic [31:0] target_velocity;
  logic        ramping;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  int          fail_count;
  int          outstanding;
  logic [31:0] model_velocity;

  // Idling limits and the request for a long receiver hold-off
  int          send_gap_max   = 0;
  int          recv_stall_max = 0;
  bit          hold_request   = 1'b0;

  // Copy of the limits last written, used to shape targets
  logic signed [31:0] floor_cfg = '0;
  logic signed [31:0] ceil_cfg  = '0;

  velocity_slew_ramp uut (.*);

  velocity_slew_ramp_checker checker_i (.*);

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(func_t f, logic [31:0] value, bit onto_current);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    target_value <= onto_current ? model_velocity : value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers, with junk above the rate and delay fields
  task automatic set_config(logic signed [31:0] lo, logic signed [31:0] hi,
                            logic [30:0] rate, logic [15:0] delay);
    write_reg(REG_MIN_VELOCITY, lo);
    write_reg(REG_MAX_VELOCITY, hi);
    write_reg(REG_MAX_STEP, {1'($urandom), rate});
    write_reg(REG_SHIFT_DELAY, {16'($urandom), delay});
    @(negedge clk);
    cfg_valid <= 1'b0;
    floor_cfg = lo;
    ceil_cfg  = hi;
  endtask

  // Drop valid and hold until every result has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] random_set_value();
    longint      lo;
    longint      hi;
    logic [63:0] rnd;
    logic [63:0] off;
    int unsigned sel;
    lo  = longint'(floor_cfg);
    hi  = longint'(ceil_cfg);
    sel = $urandom_range(0, 99);
    if (sel < 10 || lo > hi) return $urandom;
    if (sel < 16) return lo[31:0];
    if (sel < 22) return hi[31:0];
    if (sel < 27 && lo != longint'(signed'(VEL_MIN))) return 32'(lo - 1);
    if (sel < 32 && hi != longint'(signed'(VEL_MAX))) return 32'(hi + 1);
    rnd = {$urandom, $urandom};
    off = rnd % 64'(hi - lo + 1);
    return 32'(lo + longint'(off));
  endfunction

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0:       send_gap_max = 0;
      1:       send_gap_max = 2;
      default: send_gap_max = 6;
    endcase
    case ($urandom_range(0, 3))
      0:       recv_stall_max = 0;
      1:       recv_stall_max = 2;
      default: recv_stall_max = 6;
    endcase
  endtask

  task automatic pick_config(int p);
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        rate;
    logic [15:0]        delay;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 5))
      0: begin lo = VEL_MIN; hi = VEL_MAX; end
      1: begin lo = -$urandom_range(0, 1000); hi = $urandom_range(0, 1000); end
      2: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      3: begin lo = $urandom_range(1, 1000); hi = lo - $urandom_range(1, 2000); end
      4: begin lo = a >>> 8; hi = lo; end
      default: begin lo = a >>> 4; hi = lo + $urandom_range(0, 5000); end
    endcase
    case ($urandom_range(0, 5))
      0:       rate = '0;
      1:       rate = 31'd1;
      2:       rate = 31'($urandom_range(2, 50));
      3:       rate = 31'($urandom);
      4:       rate = '1;
      default: rate = 31'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(0, 9))
      0:       delay = '0;
      1:       delay = 16'd1;
      2:       delay = '1;
      default: delay = 16'($urandom_range(2, 6));
    endcase
    // Pin a few phases to the extremes
    if (p == 0) begin
      lo = VEL_MIN; hi = VEL_MAX; rate = '1; delay = '0;
    end
    if (p == 1) begin
      rate = '0; delay = 16'd1;
    end
    if (p == 3) delay = '1;
    if (p == 4) begin
      lo = VEL_MAX; hi = VEL_MIN;
    end
    set_config(lo, hi, rate, delay);
  endtask

  // Take results, stalling at random, with one long hold-off on request
  initial begin : result_sink
    int stall;
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limits: only zero is accepted, ticks while idle do nothing
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_SET, 32'd0, 1'b0);
    send_request(FUNC_SET, 32'd1, 1'b0);
    send_request(FUNC_SET, VEL_MIN, 1'b0);
    send_request(FUNC_SET, 32'hFFFF_FFFF, 1'b0);

    // Small ramps with zero delay, a rejected target and a retarget onto current
    wait_all_results();
    set_config(-1000, 1000, 31'd3, 16'd0);
    send_request(FUNC_SET, 32'd10, 1'b0);
    repeat (4) send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_SET, 32'd1001, 1'b0);
    send_request(FUNC_SET, -32'sd10, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_SET, 32'd7, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);

    // Full range, widest rate, retarget while the delay is running
    wait_all_results();
    set_config(VEL_MIN, VEL_MAX, '1, 16'd3);
    send_request(FUNC_SET, VEL_MAX, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_SET, VEL_MIN, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_TICK, $urandom, 1'b0);
    send_request(FUNC_SET, 32'd0, 1'b0);
    repeat (3) send_request(FUNC_TICK, $urandom, 1'b0);

    // Random phases, each under a fresh register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_all_results();
      pick_config(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) pick_idling();
        if (p == 2 && n == 20) begin
          hold_request = 1'b1;
          send_gap_max = 0;
        end
        if (p == 5 && n == 100) wait_all_results();
        if ($urandom_range(0, 99) < 65)
          send_request(FUNC_TICK, $urandom, 1'b0);
        else if ($urandom_range(0, 19) == 0)
          send_request(FUNC_SET, '0, 1'b1);
        else
          send_request(FUNC_SET, random_set_value(), 1'b0);
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/vsr_pkg.sv
rtl/vsr_cfg.sv
rtl/vsr_step.sv
rtl/velocity_slew_ramp.sv
bench/velocity_slew_ramp_checker.sv
bench/velocity_slew_ramp_tb.sv
